// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker in bmmc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BMMC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bmmc assertion failed");

// signal holds its value in the cycle after cond
`define BMMC_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("bmmc hold assertion failed");

`endif

// ----- rtl/bmmc_pkg.sv -----
package bmmc_pkg;

	typedef enum logic [2:0] {
		CMD_MEM_RD = 3'd0,
		CMD_MEM_WR = 3'd1,
		CMD_IO_RD  = 3'd2,
		CMD_IO_WR  = 3'd3,
		CMD_BEEP   = 3'd4,
		CMD_FDC    = 3'd5,
		CMD_MOTOR  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		TGT_RAM  = 2'd0,
		TGT_ROM  = 2'd1,
		TGT_CMOS = 2'd2,
		TGT_NONE = 2'd3
	} tgt_t;

	typedef struct packed {
		tgt_t       tgt;
		logic [6:0] page;
	} entry_t;

	// rebuild request from the port decoder to the page table
	typedef struct packed {
		logic       rebuild;
		logic       rom_sel;
		logic       cmos_sel;
		logic [7:0] bank;
	} tbl_ctrl_t;

	localparam int NUM_VAR_PAGES = 28;
	localparam int ROM_PAGES     = 4;
	localparam int CMOS_PAGE     = 16;

	localparam logic [7:0] BANK_RESET = 8'h10;
	localparam logic [7:0] IO_IDLE    = 8'hFF;

	// port groups of four, taken from port bits 7..2
	localparam logic [5:0] PG_DIP    = 6'h06;
	localparam logic [5:0] PG_ROMSEL = 6'h07;
	localparam logic [5:0] PG_CMOS   = 6'h08;
	localparam logic [5:0] PG_STATUS = 6'h0C;

	localparam int         PADDR_W = 3;
	localparam logic       REG_DIP = 1'b0;

endpackage

// ----- rtl/bmmc_page_table.sv -----
module bmmc_page_table (
	input  logic                clk,
	input  logic                arst_n,
	input  bmmc_pkg::tbl_ctrl_t ctrl,
	input  logic [4:0]          page,
	output bmmc_pkg::entry_t    entry
);

	bmmc_pkg::entry_t tbl_q [bmmc_pkg::NUM_VAR_PAGES];
	logic             bank_none;
	logic [1:0]       bank_idx;

	// lowest set bank bit among 4..7 picks the ram bank
	always_comb begin
		bank_none = 1'b0;
		bank_idx  = 2'd0;
		priority if (ctrl.bank[4]) begin
			bank_idx = 2'd0;
		end else if (ctrl.bank[5]) begin
			bank_idx = 2'd1;
		end else if (ctrl.bank[6]) begin
			bank_idx = 2'd2;
		end else if (ctrl.bank[7]) begin
			bank_idx = 2'd3;
		end else begin
			bank_none = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmmc_pkg::NUM_VAR_PAGES; i++) begin
				if (i < bmmc_pkg::ROM_PAGES) begin
					tbl_q[i] <= '{bmmc_pkg::TGT_ROM, 7'(i)};
				end else begin
					tbl_q[i] <= '{bmmc_pkg::TGT_NONE, 7'd0};
				end
			end
		end else if (ctrl.rebuild) begin
			for (int i = 0; i < bmmc_pkg::NUM_VAR_PAGES; i++) begin
				if (!ctrl.rom_sel) begin
					if (i < bmmc_pkg::ROM_PAGES) begin
						tbl_q[i] <= '{bmmc_pkg::TGT_ROM, 7'(i)};
					end else begin
						tbl_q[i] <= '{bmmc_pkg::TGT_NONE, 7'd0};
					end
				end else if (ctrl.cmos_sel && i == bmmc_pkg::CMOS_PAGE) begin
					tbl_q[i] <= '{bmmc_pkg::TGT_CMOS, 7'd0};
				end else if (ctrl.cmos_sel && i > bmmc_pkg::CMOS_PAGE) begin
					tbl_q[i] <= tbl_q[i];
				end else if (bank_none) begin
					tbl_q[i] <= '{bmmc_pkg::TGT_NONE, 7'd0};
				end else begin
					tbl_q[i] <= '{bmmc_pkg::TGT_RAM, {bank_idx, 5'(i)}};
				end
			end
		end
	end

	// top pages are fixed common ram
	always_comb begin
		if (page >= 5'(bmmc_pkg::NUM_VAR_PAGES)) begin
			entry.tgt  = bmmc_pkg::TGT_RAM;
			entry.page = {2'b00, page};
		end else begin
			entry = tbl_q[page];
		end
	end

endmodule

// ----- rtl/banked_memory_map_controller.sv -----
// banked memory map controller
// input channel (in_valid / in_stall) takes one word per cycle while in_stall
// is low: a command with address, write byte, signal level and disk-present
// flag. memory commands are translated through a 32-page table of 2 kbyte
// pages into a target store and an 18-bit physical offset; io commands read
// the dip switches or the status port, or write the bank, rom-select and
// cmos-select registers, and every io write rebuilds the table in the same
// cycle; signal commands set the beep, fdc interrupt and motor levels.
// output channel (out_valid / out_stall) gives exactly one result word per
// input word, in order, through the input register, then the result register;
// throughput is one word per cycle while out_stall is low, set by the single
// table lookup and decode between the two registers.
// when the receiver stalls, the result register holds and the input register
// keeps its word; in_stall rises only once both are full.
// reset clears both valid flags, loads the bank register with 0x10 and puts the
// table back to boot rom in the low pages, nothing mapped in the middle and
// common ram on top. dip_switches sits on an apb port at byte address 0.
module banked_memory_map_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   command,
	input  logic [15:0]                  address,
	input  logic [7:0]                   write_data,
	input  logic                         signal_level,
	input  logic                         disk_present,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   target,
	output logic [17:0]                  phys_offset,
	output logic                         mem_write_enable,
	output logic [7:0]                   mem_data,
	output logic [7:0]                   io_read_data,
	output logic                         gate_update,
	output logic                         timer_gate0,
	output logic                         timer_gate2,
	output logic                         beep_active,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmmc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// configuration register
	logic [7:0] dip_q;

	// input register
	logic                 valid_s1;
	bmmc_pkg::cmd_t       cmd_s1;
	logic [15:0]          addr_s1;
	logic [7:0]           wdata_s1;
	logic                 level_s1;
	logic                 disk_s1;

	// block state
	logic [7:0] bank_q;
	logic       rom_sel_q;
	logic       cmos_sel_q;
	logic       beep_q;
	logic       fdc_q;
	logic       motor_q;

	// result register
	logic              out_valid_q;
	bmmc_pkg::tgt_t    target_q;
	logic [17:0]       offs_q;
	logic              we_q;
	logic [7:0]        mdata_q;
	logic [7:0]        iodata_q;
	logic              gupd_q;

	logic                out_free;
	logic                fire;
	logic [5:0]          port_grp;
	bmmc_pkg::entry_t    entry;
	bmmc_pkg::tbl_ctrl_t tbl_ctrl;

	// next state and result of the word in the input register
	logic [7:0]     nxt_bank;
	logic           nxt_rom_sel;
	logic           nxt_cmos_sel;
	logic           nxt_beep;
	logic           nxt_fdc;
	logic           nxt_motor;
	bmmc_pkg::tgt_t r_tgt;
	logic [17:0]    r_offs;
	logic           r_we;
	logic [7:0]     r_mdata;
	logic [7:0]     r_io;
	logic           r_gupd;

	// apb: writes land on the access phase, no wait states
	assign pready = 1'b1;
	assign prdata = (paddr[2] == bmmc_pkg::REG_DIP) ? {24'd0, dip_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == bmmc_pkg::REG_DIP) begin
			dip_q <= pwdata[7:0];
		end
	end

	// handshake: the result register frees when empty or being taken
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign fire     = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= bmmc_pkg::cmd_t'(command);
			addr_s1  <= address;
			wdata_s1 <= write_data;
			level_s1 <= signal_level;
			disk_s1  <= disk_present;
		end
	end

	// page lookup, and table rebuild on every io write
	assign tbl_ctrl.rebuild  = fire && cmd_s1 == bmmc_pkg::CMD_IO_WR;
	assign tbl_ctrl.rom_sel  = nxt_rom_sel;
	assign tbl_ctrl.cmos_sel = nxt_cmos_sel;
	assign tbl_ctrl.bank     = nxt_bank;

	bmmc_page_table u_page_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tbl_ctrl),
		.page   (addr_s1[15:11]),
		.entry  (entry)
	);

	assign port_grp = addr_s1[7:2];

	always_comb begin
		nxt_bank     = bank_q;
		nxt_rom_sel  = rom_sel_q;
		nxt_cmos_sel = cmos_sel_q;
		nxt_beep     = beep_q;
		nxt_fdc      = fdc_q;
		nxt_motor    = motor_q;
		r_tgt        = bmmc_pkg::TGT_RAM;
		r_offs       = 18'd0;
		r_we         = 1'b0;
		r_mdata      = 8'd0;
		r_io         = bmmc_pkg::IO_IDLE;
		r_gupd       = 1'b0;
		unique case (cmd_s1)
			bmmc_pkg::CMD_MEM_RD: begin
				r_tgt  = entry.tgt;
				r_offs = {entry.page, addr_s1[10:0]};
			end
			bmmc_pkg::CMD_MEM_WR: begin
				r_tgt   = entry.tgt;
				r_offs  = {entry.page, addr_s1[10:0]};
				r_mdata = wdata_s1;
				// rom and unmapped pages drop writes
				r_we    = entry.tgt == bmmc_pkg::TGT_RAM || entry.tgt == bmmc_pkg::TGT_CMOS;
			end
			bmmc_pkg::CMD_IO_RD: begin
				if (port_grp == bmmc_pkg::PG_DIP) begin
					r_io = dip_q;
				end else if (port_grp == bmmc_pkg::PG_STATUS) begin
					r_io = {bank_q[7:4], disk_s1, 1'b0, !motor_q, fdc_q};
				end
			end
			bmmc_pkg::CMD_IO_WR: begin
				if (port_grp == bmmc_pkg::PG_DIP) begin
					nxt_bank = wdata_s1;
					r_gupd   = 1'b1;
				end else if (port_grp == bmmc_pkg::PG_ROMSEL) begin
					nxt_rom_sel = wdata_s1[0];
				end else if (port_grp == bmmc_pkg::PG_CMOS) begin
					nxt_cmos_sel = wdata_s1[0];
				end
			end
			bmmc_pkg::CMD_BEEP:  nxt_beep  = level_s1;
			bmmc_pkg::CMD_FDC:   nxt_fdc   = level_s1;
			bmmc_pkg::CMD_MOTOR: nxt_motor = level_s1;
			default: begin
				// undefined command code: no state change, idle result
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= bmmc_pkg::BANK_RESET;
			rom_sel_q  <= 1'b0;
			cmos_sel_q <= 1'b0;
			beep_q     <= 1'b0;
			fdc_q      <= 1'b0;
			motor_q    <= 1'b0;
		end else if (fire) begin
			bank_q     <= nxt_bank;
			rom_sel_q  <= nxt_rom_sel;
			cmos_sel_q <= nxt_cmos_sel;
			beep_q     <= nxt_beep;
			fdc_q      <= nxt_fdc;
			motor_q    <= nxt_motor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			target_q <= r_tgt;
			offs_q   <= r_offs;
			we_q     <= r_we;
			mdata_q  <= r_mdata;
			iodata_q <= r_io;
			gupd_q   <= r_gupd;
		end
	end

	assign out_valid        = out_valid_q;
	assign target           = target_q;
	assign phys_offset      = offs_q;
	assign mem_write_enable = we_q;
	assign mem_data         = mdata_q;
	assign io_read_data     = iodata_q;
	assign gate_update      = gupd_q;

	// state only moves when a word is loaded, so these hold with the word
	assign timer_gate0 = bank_q[0];
	assign timer_gate2 = bank_q[1];
	assign beep_active = bank_q[2] | beep_q;

endmodule

// ----- rtl/bmmc_checker.sv -----
`include "assert_macros.svh"

module bmmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  target,
	input logic [17:0] phys_offset,
	input logic        mem_write_enable,
	input logic [7:0]  mem_data,
	input logic [7:0]  io_read_data,
	input logic        gate_update
);

	// writes only reach ram or cmos
	`BMMC_ASSERT(a_we_target, clk, arst_n, out_valid && mem_write_enable |-> (target == bmmc_pkg::TGT_RAM || target == bmmc_pkg::TGT_CMOS))

	// an io read result carries no memory access
	`BMMC_ASSERT(a_io_no_mem, clk, arst_n, out_valid && io_read_data != bmmc_pkg::IO_IDLE |-> target == bmmc_pkg::TGT_RAM && phys_offset == 18'd0 && !mem_write_enable && !gate_update)

	// a bank write result carries no memory access
	`BMMC_ASSERT(a_gate_no_mem, clk, arst_n, out_valid && gate_update |-> !mem_write_enable && phys_offset == 18'd0 && mem_data == 8'd0)

	// stalled offset holds
	`BMMC_ASSERT_HOLD(a_offs_hold, clk, arst_n, out_valid && out_stall, phys_offset)

endmodule

bind banked_memory_map_controller bmmc_checker u_bmmc_checker (.*);

// ----- tb/memory_map_checker.sv -----
`timescale 1ns / 1ps

module memory_map_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [2:0]                   command,
	input  logic [15:0]                  address,
	input  logic [7:0]                   write_data,
	input  logic                         signal_level,
	input  logic                         disk_present,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [1:0]                   target,
	input  logic [17:0]                  phys_offset,
	input  logic                         mem_write_enable,
	input  logic [7:0]                   mem_data,
	input  logic [7:0]                   io_read_data,
	input  logic                         gate_update,
	input  logic                         timer_gate0,
	input  logic                         timer_gate2,
	input  logic                         beep_active,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmmc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	output int                           mismatches,
	output int                           outstanding,
	output int                           compared
);
	import bmmc_pkg::*;

	localparam logic [PADDR_W-1:0] DIP_ADDR = {REG_DIP, 2'b00};

	typedef struct packed {
		tgt_t        tgt;
		logic [17:0] offset;
		logic        wr_en;
		logic [7:0]  wr_byte;
		logic [7:0]  io_byte;
		logic        gate_upd;
		logic        gate0;
		logic        gate2;
		logic        beep;
	} map_word_t;

	entry_t     page_map [32];
	logic [7:0] bank_q;
	logic       rom_q;
	logic       cmos_q;
	logic       beep_q;
	logic       fdc_q;
	logic       motor_q;
	logic [7:0] dip_q;
	map_word_t  expected_maps [$];
	int         errors = 0;
	int         checks = 0;

	// page table as rebuilt after any port write
	function automatic void rebuild_pages();
		int         last_pg;
		logic [1:0] ram_bank;
		logic       unmapped;
		if (!rom_q) begin
			for (int i = 0; i < ROM_PAGES; i++)
				page_map[i] = entry_t'{TGT_ROM, 7'(i)};
			for (int i = ROM_PAGES; i < NUM_VAR_PAGES; i++)
				page_map[i] = entry_t'{TGT_NONE, 7'd0};
		end else begin
			last_pg  = cmos_q ? CMOS_PAGE - 1 : NUM_VAR_PAGES - 1;
			unmapped = 1'b0;
			ram_bank = 2'd0;
			if (bank_q[4]) ram_bank = 2'd0;
			else if (bank_q[5]) ram_bank = 2'd1;
			else if (bank_q[6]) ram_bank = 2'd2;
			else if (bank_q[7]) ram_bank = 2'd3;
			else unmapped = 1'b1;
			// in cmos mode the pages above the cmos page keep what they had
			for (int i = 0; i <= last_pg; i++)
				page_map[i] = unmapped ? entry_t'{TGT_NONE, 7'd0}
				                       : entry_t'{TGT_RAM, {ram_bank, 5'(i)}};
			if (cmos_q)
				page_map[CMOS_PAGE] = entry_t'{TGT_CMOS, 7'd0};
		end
		for (int i = NUM_VAR_PAGES; i < 32; i++)
			page_map[i] = entry_t'{TGT_RAM, 7'(i)};
	endfunction

	function automatic map_word_t predict_map(input logic [2:0] cmd, input logic [15:0] addr,
			input logic [7:0] data, input logic lvl, input logic disk);
		map_word_t  r;
		entry_t     e;
		logic [5:0] grp;
		r = '0;
		r.io_byte = IO_IDLE;
		grp = addr[7:2];
		case (cmd)
			CMD_MEM_RD, CMD_MEM_WR: begin
				e = page_map[addr[15:11]];
				r.tgt = e.tgt;
				r.offset = {e.page, addr[10:0]};
				if (cmd == CMD_MEM_WR) begin
					r.wr_byte = data;
					r.wr_en = (e.tgt == TGT_RAM) || (e.tgt == TGT_CMOS);
				end
			end
			CMD_IO_RD: begin
				if (grp == PG_DIP)
					r.io_byte = dip_q;
				else if (grp == PG_STATUS)
					r.io_byte = {bank_q[7:4], disk, 1'b0, ~motor_q, fdc_q};
			end
			CMD_IO_WR: begin
				if (grp == PG_DIP) begin
					bank_q = data;
					r.gate_upd = 1'b1;
				end else if (grp == PG_ROMSEL) begin
					rom_q = data[0];
				end else if (grp == PG_CMOS) begin
					cmos_q = data[0];
				end
				rebuild_pages();
			end
			CMD_BEEP:  beep_q = lvl;
			CMD_FDC:   fdc_q = lvl;
			CMD_MOTOR: motor_q = lvl;
			default: ;
		endcase
		r.gate0 = bank_q[0];
		r.gate2 = bank_q[1];
		r.beep  = bank_q[2] | beep_q;
		return r;
	endfunction

	task automatic check_field(input string label, input logic [17:0] want,
			input logic [17:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		map_word_t want;
		if (!arst_n) begin
			bank_q  = BANK_RESET;
			rom_q   = 1'b0;
			cmos_q  = 1'b0;
			beep_q  = 1'b0;
			fdc_q   = 1'b0;
			motor_q = 1'b0;
			dip_q   = '0;
			rebuild_pages();
			expected_maps.delete();
			outstanding <= 0;
			mismatches  <= errors;
			compared    <= checks;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_maps.size() == 0) begin
					$display("%0t: result word with nothing expected, expected none, actual %0h/%0h",
						$time, target, phys_offset);
					errors++;
				end else begin
					want = expected_maps.pop_front();
					checks++;
					check_field("target", 18'(want.tgt), 18'(target));
					check_field("phys_offset", want.offset, phys_offset);
					check_field("mem_write_enable", 18'(want.wr_en), 18'(mem_write_enable));
					check_field("mem_data", 18'(want.wr_byte), 18'(mem_data));
					check_field("io_read_data", 18'(want.io_byte), 18'(io_read_data));
					check_field("gate_update", 18'(want.gate_upd), 18'(gate_update));
					check_field("timer_gate0", 18'(want.gate0), 18'(timer_gate0));
					check_field("timer_gate2", 18'(want.gate2), 18'(timer_gate2));
					check_field("beep_active", 18'(want.beep), 18'(beep_active));
				end
			end
			if (in_valid && !in_stall)
				expected_maps.push_back(predict_map(command, address, write_data,
					signal_level, disk_present));
			if (psel && penable && pwrite && pready && paddr == DIP_ADDR)
				dip_q = pwdata[7:0];
			outstanding <= expected_maps.size();
			mismatches  <= errors;
			compared    <= checks;
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import bmmc_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_WORDS = 1350;
	localparam int PHASES       = 4;
	// command code outside the defined set, must leave all state alone
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [PADDR_W-1:0] DIP_ADDR = {REG_DIP, 2'b00};

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;

	logic               clk;
	logic               arst_n = 1'b0;
	// input channel, all driven to known values from time zero
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         command = '0;
	logic [15:0]        address = '0;
	logic [7:0]         write_data = '0;
	logic               signal_level = 1'b0;
	logic               disk_present = 1'b0;
	// output channel
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         target;
	logic [17:0]        phys_offset;
	logic               mem_write_enable;
	logic [7:0]         mem_data;
	logic [7:0]         io_read_data;
	logic               gate_update;
	logic               timer_gate0;
	logic               timer_gate2;
	logic               beep_active;
	// apb side
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int mismatches;
	int outstanding;
	int compared;

	// driver bookkeeping
	int burst_left = 0;
	int words_sent = 0;
	int mem_words = 0;
	int io_words = 0;
	int sig_words = 0;
	int dip_settings = 0;

	banked_memory_map_controller u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.address          (address),
		.write_data       (write_data),
		.signal_level     (signal_level),
		.disk_present     (disk_present),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.target           (target),
		.phys_offset      (phys_offset),
		.mem_write_enable (mem_write_enable),
		.mem_data         (mem_data),
		.io_read_data     (io_read_data),
		.gate_update      (gate_update),
		.timer_gate0      (timer_gate0),
		.timer_gate2      (timer_gate2),
		.beep_active      (beep_active),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	memory_map_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.address          (address),
		.write_data       (write_data),
		.signal_level     (signal_level),
		.disk_present     (disk_present),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.target           (target),
		.phys_offset      (phys_offset),
		.mem_write_enable (mem_write_enable),
		.mem_data         (mem_data),
		.io_read_data     (io_read_data),
		.gate_update      (gate_update),
		.timer_gate0      (timer_gate0),
		.timer_gate2      (timer_gate2),
		.beep_active      (beep_active),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.compared         (compared)
	);

	// 100 mhz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure: a mode is held for a while, then another is drawn
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          stall_phase = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(32, 200);
		end else begin
			stall_left--;
		end
		stall_phase++;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (stall_phase % 5) < 2;
		endcase
	end

	// watchdog: too long with no word moving on either side, or on the apb port
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time, outstanding);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// present one word and hold it until taken; bursts end in a random gap
	task automatic send_word(input logic [2:0] cmd, input logic [15:0] addr,
			input logic [7:0] data, input logic lvl, input logic disk);
		in_valid     <= 1'b1;
		command      <= cmd;
		address      <= addr;
		write_data   <= data;
		signal_level <= lvl;
		disk_present <= disk;
		do @(posedge clk); while (in_stall);
		words_sent++;
		case (cmd)
			CMD_MEM_RD, CMD_MEM_WR: mem_words++;
			CMD_IO_RD, CMD_IO_WR:   io_words++;
			default:                sig_words++;
		endcase
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
			                                         : $urandom_range(1, 12);
		end
	endtask

	// let the pipeline run dry before touching the register
	task automatic settle();
		if (in_valid)
			in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dip(input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DIP_ADDR;
		pwdata  <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		dip_settings++;
	endtask

	function automatic logic [7:0] pick_port();
		logic [1:0] sub;
		sub = 2'($urandom);
		case ($urandom_range(0, 4))
			0:       return {PG_DIP, sub};
			1:       return {PG_ROMSEL, sub};
			2:       return {PG_CMOS, sub};
			3:       return {PG_STATUS, sub};
			default: return 8'($urandom);
		endcase
	endfunction

	// any single word, memory traffic weighted highest
	task automatic random_word();
		int          pick;
		logic [2:0]  cmd;
		logic [15:0] addr;
		pick = $urandom_range(0, 99);
		addr = 16'($urandom);
		if (pick < 35) begin
			cmd = CMD_MEM_RD;
		end else if (pick < 55) begin
			cmd = CMD_MEM_WR;
		end else if (pick < 70) begin
			cmd = CMD_IO_RD;
			addr[7:0] = pick_port();
		end else if (pick < 85) begin
			cmd = CMD_IO_WR;
			addr[7:0] = pick_port();
		end else if (pick < 98) begin
			case ($urandom_range(0, 2))
				0:       cmd = CMD_BEEP;
				1:       cmd = CMD_FDC;
				default: cmd = CMD_MOTOR;
			endcase
		end else begin
			cmd = CMD_UNUSED;
		end
		send_word(cmd, addr, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// map some ram in, maybe switch cmos on, then hit the pages
	task automatic mapping_sequence();
		logic [7:0]  data;
		logic [15:0] addr;
		data = 8'($urandom);
		if ($urandom_range(0, 9) != 0)
			data[0] = 1'b1;
		send_word(CMD_IO_WR, {8'($urandom), PG_ROMSEL, 2'($urandom)}, data,
			1'($urandom), 1'($urandom));
		data = 8'($urandom);
		if ($urandom_range(0, 4) == 0)
			data[7:4] = 4'h0;
		send_word(CMD_IO_WR, {8'($urandom), PG_DIP, 2'($urandom)}, data,
			1'($urandom), 1'($urandom));
		if ($urandom_range(0, 1))
			send_word(CMD_IO_WR, {8'($urandom), PG_CMOS, 2'($urandom)}, 8'($urandom),
				1'($urandom), 1'($urandom));
		// second bank write shows which pages were kept under cmos
		if ($urandom_range(0, 2) == 0)
			send_word(CMD_IO_WR, {8'($urandom), PG_DIP, 2'($urandom)}, 8'($urandom),
				1'($urandom), 1'($urandom));
		repeat ($urandom_range(3, 10)) begin
			addr = 16'($urandom);
			if ($urandom_range(0, 1))
				addr[15:11] = 5'($urandom_range(CMOS_PAGE, NUM_VAR_PAGES - 1));
			send_word($urandom_range(0, 1) ? CMD_MEM_WR : CMD_MEM_RD, addr, 8'($urandom),
				1'($urandom), 1'($urandom));
		end
	endtask

	initial begin : stimulus
		int phase_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_dip(8'hA5);

		// directed words, starting from the reset map
		send_word(CMD_MEM_RD, 16'h0000, 8'h00, 1'b0, 1'b0);  // boot rom, lowest address
		send_word(CMD_MEM_WR, 16'h1FFF, 8'hFF, 1'b1, 1'b1);  // rom write dropped
		send_word(CMD_MEM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b0);  // common ram, top address
		send_word(CMD_MEM_WR, 16'hE000, 8'h00, 1'b0, 1'b0);  // common ram write
		send_word(CMD_MEM_WR, 16'h8800, 8'h5A, 1'b0, 1'b0);  // unmapped write dropped
		send_word(CMD_IO_RD, 16'hFF18, 8'h00, 1'b0, 1'b0);   // dip switches
		send_word(CMD_IO_RD, 16'h0033, 8'h00, 1'b0, 1'b1);   // status, disk in
		send_word(CMD_IO_RD, 16'h00FF, 8'h00, 1'b0, 1'b0);   // unmapped port
		send_word(CMD_BEEP, 16'h0000, 8'h00, 1'b1, 1'b0);
		send_word(CMD_FDC, 16'h0000, 8'h00, 1'b1, 1'b0);
		send_word(CMD_MOTOR, 16'h0000, 8'h00, 1'b1, 1'b0);
		send_word(CMD_IO_RD, 16'hAB30, 8'h00, 1'b0, 1'b0);   // status with irq and motor
		send_word(CMD_IO_WR, 16'h001C, 8'hFF, 1'b0, 1'b0);   // ram in low pages, bank 0
		send_word(CMD_MEM_RD, 16'h7800, 8'h00, 1'b0, 1'b0);
		send_word(CMD_MEM_WR, 16'hDFFF, 8'h3C, 1'b0, 1'b0);  // last variable page
		send_word(CMD_IO_WR, 16'h001B, 8'h87, 1'b0, 1'b0);   // bank 3, gates and beep
		send_word(CMD_IO_WR, 16'h0020, 8'h01, 1'b0, 1'b0);   // cmos on
		send_word(CMD_MEM_WR, 16'h8123, 8'hC3, 1'b0, 1'b0);  // cmos page
		send_word(CMD_IO_WR, 16'h0019, 8'h0F, 1'b0, 1'b0);   // no ram bank selected
		send_word(CMD_MEM_RD, 16'h0000, 8'h00, 1'b0, 1'b0);  // now unmapped
		send_word(CMD_MEM_RD, 16'hD000, 8'h00, 1'b0, 1'b0);  // kept bank 3 mapping
		send_word(CMD_IO_WR, 16'hFF40, 8'h00, 1'b0, 1'b0);   // other port, rebuild only
		send_word(CMD_IO_WR, 16'h0023, 8'hFE, 1'b0, 1'b0);   // cmos off, bit 0 only
		send_word(CMD_IO_WR, 16'h001E, 8'h00, 1'b0, 1'b0);   // back to boot rom
		send_word(CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 1'b1);  // unused command
		send_word(CMD_BEEP, 16'h0000, 8'h00, 1'b0, 1'b0);

		// random phases, each under its own dip setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_dip(ph == 0 ? 8'h00 : (ph == 1 ? 8'hFF : 8'($urandom)));
			phase_start = words_sent;
			while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
				if ($urandom_range(0, 99) < 55)
					mapping_sequence();
				else
					random_word();
			end
		end
		settle();

		$display("summary: %0d words in (%0d memory, %0d io, %0d signal), %0d dip settings",
			words_sent, mem_words, io_words, sig_words, dip_settings);
		$display("summary: %0d result words compared, %0d field mismatches",
			compared, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- banked_memory_map_controller.f -----
+incdir+rtl
rtl/bmmc_pkg.sv
rtl/bmmc_page_table.sv
rtl/banked_memory_map_controller.sv
rtl/bmmc_checker.sv
tb/memory_map_checker.sv
tb/tb.sv
